/* design/dept_pkg.sv */
// ----------------------------------------------------------------------------
// dept_pkg
// Types and constants shared by the double-ended priority table block.
// ----------------------------------------------------------------------------
package dept_pkg;

  localparam int CAPACITY   = 64;
  localparam int ID_BITS    = 16;
  localparam int LEVEL_BITS = 8;
  localparam int SLOT_BITS  = $clog2(CAPACITY);
  localparam int QDEPTH     = 2;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_HARDEST = 2'd1,
    KIND_EASIEST = 2'd2,
    KIND_REMOVE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ID_BITS-1:0]    item_id;
    logic [LEVEL_BITS-1:0] level;
  } cmd_t;

  typedef struct packed {
    logic [ID_BITS-1:0] result_id;
    status_t            status;
  } res_t;

endpackage

/* design/dept_if.sv */
// ----------------------------------------------------------------------------
// dept_cmd_if / dept_res_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface dept_cmd_if;
  import dept_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [ID_BITS-1:0]    item_id;
  logic [LEVEL_BITS-1:0] level;
  modport source (output valid, kind, item_id, level, input ready);
  modport sink (input valid, kind, item_id, level, output ready);
endinterface

interface dept_res_if;
  import dept_pkg::*;
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] result_id;
  logic [1:0]         status;
  modport source (output valid, result_id, status, input ready);
  modport sink (input valid, result_id, status, output ready);
endinterface

/* design/double_ended_priority_table_core.sv */
// a command waits in the queue, then the table is scanned one slot per cycle;
// the result is registered after the last slot scanned (all CAPACITY slots
// for queries and removes, an add stops at the first free slot)
// a new command starts only once the previous scan has ended and the result
// register is free; the single shared compare cell scans for one command
// reset: all table entries invalid, queue and result register empty
// ----------------------------------------------------------------------------
// double_ended_priority_table_core
// Table of identifier/level entries with max/min query, add and remove.
// ----------------------------------------------------------------------------
module double_ended_priority_table_core (
  input  logic       clk,
  input  logic       rst_n,
  dept_cmd_if.sink   in_cmd,
  dept_res_if.source out_res
);
  import dept_pkg::*;

  cmd_t q_data;
  logic q_valid, q_pop;

  dept_front u_front (.clk, .rst_n, .cmd(in_cmd), .q_data, .q_valid, .q_pop);
  dept_back  u_back  (.clk, .rst_n, .q_data, .q_valid, .q_pop, .res(out_res));
endmodule

/* design/dept_front.sv */
// ----------------------------------------------------------------------------
// dept_front
// Accepts commands, masks the kind into its enum and queues them.
// ----------------------------------------------------------------------------
module dept_front (
  input  logic            clk,
  input  logic            rst_n,
  dept_cmd_if.sink        cmd,
  output dept_pkg::cmd_t  q_data,
  output logic            q_valid,
  input  logic            q_pop
);
  import dept_pkg::*;

  cmd_t                  mem_r [QDEPTH];
  logic [$clog2(QDEPTH):0] cnt_r, cnt_nxt;
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic push;

  assign cmd.ready = (cnt_r != QDEPTH[$clog2(QDEPTH):0]);
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (cnt_r != '0);
  assign q_data    = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop && q_valid) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop && q_valid) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{kind: kind_t'(cmd.kind), item_id: cmd.item_id,
                              level: cmd.level};
  end
endmodule

/* design/dept_back.sv */
// ----------------------------------------------------------------------------
// dept_back
// Executes one command: scans the table over cells, then emits the result.
// ----------------------------------------------------------------------------
module dept_back (
  input  logic           clk,
  input  logic           rst_n,
  input  dept_pkg::cmd_t q_data,
  input  logic           q_valid,
  output logic           q_pop,
  dept_res_if.source     res
);
  import dept_pkg::*;

  logic [CAPACITY-1:0]           valid_r;
  logic [ID_BITS+LEVEL_BITS-1:0] ent_r [CAPACITY];
  logic [ID_BITS+LEVEL_BITS-1:0] rd_r;

  cmd_t                  cur_r;
  logic                  busy_r;
  logic [SLOT_BITS-1:0]  idx_r;
  logic                  found_r;
  logic [ID_BITS-1:0]    bi_r;
  logic [LEVEL_BITS-1:0] bl_r;
  logic                  ovalid_r;
  res_t                  ores_r, ores_nxt;

  logic [SLOT_BITS-1:0]  ix, ra;
  logic [ID_BITS-1:0]    rd_id;
  logic [LEVEL_BITS-1:0] rd_lvl;
  logic                  last, hit, better, done, we;
  assign ix   = idx_r;
  assign last = (idx_r == SLOT_BITS'(CAPACITY-1));

  // can start a new command once the result register is free
  assign q_pop = q_valid && !busy_r && (!ovalid_r || res.ready);
  assign res.valid     = ovalid_r;
  assign res.result_id = ores_r.result_id;
  assign res.status    = ores_r.status;

  // read one slot ahead so that rd_r holds the slot under scan
  assign ra     = q_pop ? '0 : ix + 1'b1;
  assign rd_id  = rd_r[LEVEL_BITS +: ID_BITS];
  assign rd_lvl = rd_r[LEVEL_BITS-1:0];
  assign hit    = valid_r[ix] && (rd_id == cur_r.item_id);
  assign we     = busy_r && (cur_r.kind == KIND_ADD) && !valid_r[ix];

  always_comb begin
    better = 1'b0;
    if (valid_r[ix]) begin
      if (!found_r) better = 1'b1;
      else if (cur_r.kind == KIND_HARDEST)
        better = (rd_lvl != bl_r) ? (rd_lvl > bl_r) : (rd_id > bi_r);
      else
        better = (rd_lvl != bl_r) ? (rd_lvl < bl_r) : (rd_id < bi_r);
    end
    done = busy_r && (last || (cur_r.kind == KIND_ADD && !valid_r[ix]));
  end

  always_comb begin
    ores_nxt.result_id = '0;
    ores_nxt.status    = ST_OK;
    case (cur_r.kind)
      KIND_ADD: begin
        if (valid_r[ix]) ores_nxt.status = ST_FULL;
      end
      KIND_REMOVE: begin
        if (!(found_r || hit)) ores_nxt.status = ST_ABSENT;
      end
      default: begin
        if (better) ores_nxt.result_id = rd_id;
        else if (found_r) ores_nxt.result_id = bi_r;
        else ores_nxt.status = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (q_pop) busy_r <= 1'b1;
      else if (done) busy_r <= 1'b0;
      if (done) ovalid_r <= 1'b1;
      else if (res.ready) ovalid_r <= 1'b0;
      if (busy_r) begin
        case (cur_r.kind)
          KIND_ADD: begin
            if (!valid_r[ix]) valid_r[ix] <= 1'b1;
          end
          KIND_REMOVE: begin
            if (hit) valid_r[ix] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) ent_r[ix] <= {cur_r.item_id, cur_r.level};
    rd_r <= ent_r[ra];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r   <= q_data;
      idx_r   <= '0;
      found_r <= 1'b0;
      bi_r    <= '0;
      bl_r    <= '0;
    end else if (busy_r) begin
      idx_r <= idx_r + 1'b1;
      case (cur_r.kind)
        KIND_ADD: ;
        KIND_REMOVE: begin
          if (hit) found_r <= 1'b1;
        end
        default: begin
          if (better) begin
            found_r <= 1'b1;
            bi_r    <= rd_id;
            bl_r    <= rd_lvl;
          end
        end
      endcase
      if (done) ores_r <= ores_nxt;
    end
  end
endmodule
